FILE: src/r2h_pkg.sv
package r2h_pkg;

	// Pixel channel width and hue field width
	localparam int PIX_W = 8;
	localparam int HUE_W = 15;

	// Wide enough for 360 degrees at the largest fraction setting plus a quotient
	localparam int HUE_SUM_W = 18;

	// Hue sector geometry in degrees
	localparam int DEG_SECTOR = 60;
	localparam int DEG_GREEN  = 120;
	localparam int DEG_BLUE   = 240;
	localparam int DEG_FULL   = 360;

	// Saturation full scale
	localparam int SAT_SCALE = 255;

	// Base angle of the hue sector
	typedef enum logic [1:0] {
		BASE_0   = 2'd0,
		BASE_120 = 2'd1,
		BASE_240 = 2'd2,
		BASE_360 = 2'd3
	} hue_base_t;

	// Per-pixel sideband that rides along the divider chain
	typedef struct packed {
		logic [PIX_W-1:0] bright;
		logic [PIX_W-1:0] delta;
		hue_base_t        base;
		logic             neg;
	} r2h_side_t;

endpackage

FILE: src/r2h_prep.sv
module r2h_prep #(
	parameter int HUE_FRAC_BITS = 6,
	parameter int DIV_W = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [r2h_pkg::PIX_W-1:0]   red,
	input  logic [r2h_pkg::PIX_W-1:0]   green,
	input  logic [r2h_pkg::PIX_W-1:0]   blue,
	output logic                        out_valid,
	input  logic                        out_ready,
	output r2h_pkg::r2h_side_t          side,
	output logic [r2h_pkg::PIX_W-1:0]   hrem,
	output logic [DIV_W-1:0]            hnq,
	output logic [r2h_pkg::PIX_W-1:0]   srem,
	output logic [DIV_W-1:0]            snq
);

	localparam int PW = r2h_pkg::PIX_W;
	localparam int NUM_W = DIV_W + PW;

	logic                 r_max;
	logic                 g_max;
	logic [PW-1:0]        mx;
	logic [PW-1:0]        mn;
	logic [PW-1:0]        mag;
	r2h_pkg::r2h_side_t   side_d;
	logic [NUM_W-1:0]     hnum;
	logic [NUM_W-1:0]     snum;
	logic                 valid_s1;
	r2h_pkg::r2h_side_t   side_s1;
	logic [PW-1:0]        hrem_s1;
	logic [DIV_W-1:0]     hnq_s1;
	logic [PW-1:0]        srem_s1;
	logic [DIV_W-1:0]     snq_s1;

	always_comb begin
		r_max = (red >= green) && (red >= blue);
		g_max = !r_max && (green >= blue);
		mx = r_max ? red : (g_max ? green : blue);
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
		side_d.bright = mx;
		side_d.delta = mx - mn;
		if (r_max) begin
			side_d.neg = green < blue;
			mag = side_d.neg ? (blue - green) : (green - blue);
			side_d.base = side_d.neg ? r2h_pkg::BASE_360 : r2h_pkg::BASE_0;
		end else if (g_max) begin
			side_d.neg = blue < red;
			mag = side_d.neg ? (red - blue) : (blue - red);
			side_d.base = r2h_pkg::BASE_120;
		end else begin
			side_d.neg = red < green;
			mag = side_d.neg ? (green - red) : (red - green);
			side_d.base = r2h_pkg::BASE_240;
		end
		// 60 * |diff| scaled to fraction bits, and 255 * delta
		hnum = (NUM_W'(mag) * NUM_W'(r2h_pkg::DEG_SECTOR)) << HUE_FRAC_BITS;
		snum = NUM_W'(side_d.delta) * NUM_W'(r2h_pkg::SAT_SCALE);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			side_s1 <= side_d;
			hrem_s1 <= hnum[NUM_W-1:DIV_W];
			hnq_s1  <= hnum[DIV_W-1:0];
			srem_s1 <= snum[NUM_W-1:DIV_W];
			snq_s1  <= snum[DIV_W-1:0];
		end
	end

	assign out_valid = valid_s1;
	assign side = side_s1;
	assign hrem = hrem_s1;
	assign hnq = hnq_s1;
	assign srem = srem_s1;
	assign snq = snq_s1;

endmodule

FILE: src/r2h_div_cell.sv
module r2h_div_cell #(
	parameter int DIV_W = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  r2h_pkg::r2h_side_t          in_side,
	input  logic [r2h_pkg::PIX_W-1:0]   in_hrem,
	input  logic [DIV_W-1:0]            in_hnq,
	input  logic [r2h_pkg::PIX_W-1:0]   in_srem,
	input  logic [DIV_W-1:0]            in_snq,
	output logic                        out_valid,
	input  logic                        out_ready,
	output r2h_pkg::r2h_side_t          out_side,
	output logic [r2h_pkg::PIX_W-1:0]   out_hrem,
	output logic [DIV_W-1:0]            out_hnq,
	output logic [r2h_pkg::PIX_W-1:0]   out_srem,
	output logic [DIV_W-1:0]            out_snq
);

	localparam int PW = r2h_pkg::PIX_W;

	logic               valid_q;
	r2h_pkg::r2h_side_t side_q;
	logic [PW-1:0]      hrem_q;
	logic [DIV_W-1:0]   hnq_q;
	logic [PW-1:0]      srem_q;
	logic [DIV_W-1:0]   snq_q;
	logic [PW:0]        ht;
	logic [PW:0]        st;
	logic               hge;
	logic               sge;
	logic [PW:0]        hdiff;
	logic [PW:0]        sdiff;

	// One restoring step per lane: bring down the next dividend bit, subtract if it fits
	always_comb begin
		ht = {in_hrem, in_hnq[DIV_W-1]};
		st = {in_srem, in_snq[DIV_W-1]};
		hdiff = ht - {1'b0, in_side.delta};
		sdiff = st - {1'b0, in_side.bright};
		hge = ht >= {1'b0, in_side.delta};
		sge = st >= {1'b0, in_side.bright};
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			side_q <= in_side;
			hrem_q <= hge ? hdiff[PW-1:0] : ht[PW-1:0];
			hnq_q  <= {in_hnq[DIV_W-2:0], hge};
			srem_q <= sge ? sdiff[PW-1:0] : st[PW-1:0];
			snq_q  <= {in_snq[DIV_W-2:0], sge};
		end
	end

	assign out_valid = valid_q;
	assign out_side = side_q;
	assign out_hrem = hrem_q;
	assign out_hnq = hnq_q;
	assign out_srem = srem_q;
	assign out_snq = snq_q;

endmodule

FILE: src/rgb_to_hsv_pixel.sv
// RGB to HSV converter for 8-bit pixels. One beat in carries red, green and
// blue; one beat out carries hue (1/2^HUE_FRAC_BITS degree, 0..23039 at the
// default of 6), saturation (255 = 1.0, truncated) and brightness (the
// largest channel). Gray and black pixels give hue 0 and saturation 0; ties
// for the largest channel go to red, then green. The block takes one pixel
// every clock while in_stall is low and keeps no state between pixels. A
// front stage finds max, min and the hue sector and forms both dividends,
// then a chain of DIV_W identical divider cells produces one quotient bit
// each for the hue and saturation divisions side by side, and a final stage
// adds the sector base and registers the result. Each cell holds a pixel
// until the next one has room, so empty slots collapse and the input side
// keeps accepting while a finished beat waits on out_stall; in_stall rises
// only when the front stage, every cell and the output register are full.
module rgb_to_hsv_pixel #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [r2h_pkg::PIX_W-1:0]   red,
	input  logic [r2h_pkg::PIX_W-1:0]   green,
	input  logic [r2h_pkg::PIX_W-1:0]   blue,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [r2h_pkg::HUE_W-1:0]   hue,
	output logic [r2h_pkg::PIX_W-1:0]   saturation,
	output logic [r2h_pkg::PIX_W-1:0]   brightness
);

	localparam int PW = r2h_pkg::PIX_W;
	localparam int SW = r2h_pkg::HUE_SUM_W;
	// Hue quotient reaches 60 << HUE_FRAC_BITS; saturation needs a full byte
	localparam int HUE_Q_W = $clog2(r2h_pkg::DEG_SECTOR * (1 << HUE_FRAC_BITS) + 1);
	localparam int DIV_W = (HUE_Q_W > PW) ? HUE_Q_W : PW;

	// Links between chain elements; index 0 is the front stage output
	logic                 lnk_valid [DIV_W+1];
	logic                 lnk_ready [DIV_W+1];
	r2h_pkg::r2h_side_t   lnk_side  [DIV_W+1];
	logic [PW-1:0]        lnk_hrem  [DIV_W+1];
	logic [DIV_W-1:0]     lnk_hnq   [DIV_W+1];
	logic [PW-1:0]        lnk_srem  [DIV_W+1];
	logic [DIV_W-1:0]     lnk_snq   [DIV_W+1];

	logic                 front_ready;
	logic                 out_ready;
	logic                 out_valid_q;
	logic [r2h_pkg::HUE_W-1:0] hue_q;
	logic [PW-1:0]        saturation_q;
	logic [PW-1:0]        brightness_q;

	r2h_pkg::r2h_side_t   fin_side;
	logic [SW-1:0]        base_val;
	logic [SW-1:0]        hue_sum;
	logic [SW-1:0]        quo_ext;
	logic [SW-1:0]        rnd_ext;
	logic                 gray;

	assign in_stall = !front_ready;

	r2h_prep #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS),
		.DIV_W         (DIV_W)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (front_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (lnk_valid[0]),
		.out_ready (lnk_ready[0]),
		.side      (lnk_side[0]),
		.hrem      (lnk_hrem[0]),
		.hnq       (lnk_hnq[0]),
		.srem      (lnk_srem[0]),
		.snq       (lnk_snq[0])
	);

	// One quotient bit per cell for both divisions
	for (genvar gi = 0; gi < DIV_W; gi++) begin : g_cell
		r2h_div_cell #(
			.DIV_W (DIV_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (lnk_valid[gi]),
			.in_ready  (lnk_ready[gi]),
			.in_side   (lnk_side[gi]),
			.in_hrem   (lnk_hrem[gi]),
			.in_hnq    (lnk_hnq[gi]),
			.in_srem   (lnk_srem[gi]),
			.in_snq    (lnk_snq[gi]),
			.out_valid (lnk_valid[gi+1]),
			.out_ready (lnk_ready[gi+1]),
			.out_side  (lnk_side[gi+1]),
			.out_hrem  (lnk_hrem[gi+1]),
			.out_hnq   (lnk_hnq[gi+1]),
			.out_srem  (lnk_srem[gi+1]),
			.out_snq   (lnk_snq[gi+1])
		);
	end

	// Final stage: add or subtract the quotient against the sector base.
	// A negative difference rounds toward zero, so drop one more when the
	// division left a remainder.
	always_comb begin
		fin_side = lnk_side[DIV_W];
		gray = fin_side.delta == '0;
		case (fin_side.base)
			r2h_pkg::BASE_0:   base_val = '0;
			r2h_pkg::BASE_120: base_val = SW'(r2h_pkg::DEG_GREEN) << HUE_FRAC_BITS;
			r2h_pkg::BASE_240: base_val = SW'(r2h_pkg::DEG_BLUE) << HUE_FRAC_BITS;
			r2h_pkg::BASE_360: base_val = SW'(r2h_pkg::DEG_FULL) << HUE_FRAC_BITS;
			default:           base_val = '0;
		endcase
		quo_ext = SW'(lnk_hnq[DIV_W]);
		rnd_ext = SW'(|lnk_hrem[DIV_W]);
		if (fin_side.neg) begin
			hue_sum = base_val - quo_ext - rnd_ext;
		end else begin
			hue_sum = base_val + quo_ext;
		end
	end

	assign out_ready = !out_valid_q || !out_stall;
	assign lnk_ready[DIV_W] = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= lnk_valid[DIV_W];
		end
	end

	// Hold the result while the beat is stalled; load a fresh one otherwise
	always_ff @(posedge clk) begin
		if (out_ready && lnk_valid[DIV_W]) begin
			hue_q        <= gray ? '0 : hue_sum[r2h_pkg::HUE_W-1:0];
			saturation_q <= gray ? '0 : lnk_snq[DIV_W][PW-1:0];
			brightness_q <= fin_side.bright;
		end
	end

	assign out_valid = out_valid_q;
	assign hue = hue_q;
	assign saturation = saturation_q;
	assign brightness = brightness_q;

	// Input stalls only when the whole chain is full behind a stalled output
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

	// Black pixel has no color
	a_black_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && brightness == '0) |-> (saturation == '0 && hue == '0))
		else $error("black pixel with nonzero hue or saturation");

	// Any chroma gives at least one step of saturation, so zero saturation means gray
	a_gray_zero_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturation == '0) |-> (hue == '0))
		else $error("gray pixel with nonzero hue");

	// Hue stays below a full turn wherever the field holds it
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((HUE_FRAC_BITS > 6)
			|| (SW'(hue) < (SW'(r2h_pkg::DEG_FULL) << HUE_FRAC_BITS))))
		else $error("hue at or beyond 360 degrees");

endmodule
